### hdl/sorted_insert_table_defines.svh
// assertion macros shared by the sorted insert table modules
`ifndef SORTED_INSERT_TABLE_DEFINES_SVH
`define SORTED_INSERT_TABLE_DEFINES_SVH

// same-cycle implication, checked on clk, masked during rst
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, masked during rst
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/sit_pkg.sv
// shared types and constants of the sorted insert table
package sit_pkg;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 4;
  localparam int FIELD_CNT_W = 5;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start_read;
    logic start_insert;
    logic refuse;
    logic shift;
    logic place;
    logic take_read;
    logic push;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic ptr_one;
    logic shift_ok;
  } status_t;

endpackage

### hdl/sit_ifs.sv
// request and response channel interfaces of the sorted insert table
interface sit_in_if;
  import sit_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;

  modport source (output valid, output kind, output value, output index, input ready);
  modport sink (input valid, input kind, input value, input index, output ready);
endinterface

interface sit_out_if;
  import sit_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FIELD_CNT_W-1:0]    position;
  logic signed [VALUE_W-1:0] read_value;
  logic [FIELD_CNT_W-1:0]    entry_count;
  logic                      table_empty;
  logic                      error;

  modport source (output valid, output position, output read_value, output entry_count,
                  output table_empty, output error, input ready);
  modport sink (input valid, input position, input read_value, input entry_count,
                input table_empty, input error, output ready);
endinterface

### hdl/sit_datapath.sv
// table memory, count, scan pointer and result registers
module sit_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sit_pkg::cmd_t                     cmd,
  output sit_pkg::status_t                  status,
  input  logic signed [sit_pkg::VALUE_W-1:0] value,
  input  logic [sit_pkg::INDEX_W-1:0]       index,
  output logic [sit_pkg::FIELD_CNT_W-1:0]   position,
  output logic signed [sit_pkg::VALUE_W-1:0] read_value,
  output logic [sit_pkg::FIELD_CNT_W-1:0]   entry_count,
  output logic                              table_empty,
  output logic                              error
);
  import sit_pkg::*;

  `include "sorted_insert_table_defines.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] val;
  logic [AW-1:0]             rd_addr;
  logic [CW-1:0]             count;
  logic [CW-1:0]             ptr;
  logic [CW-1:0]             ptr_m2;
  logic [CW-1:0]             cnt_m1;
  logic                      rd_err;
  logic [CW-1:0]             res_position;
  logic signed [VALUE_W-1:0] res_read_value;
  logic                      res_error;

  assign ptr_m2 = ptr - CW'(2);
  assign cnt_m1 = count - CW'(1);

  // read address: requested index, top entry, or the one below the next hole
  always_comb begin
    rd_addr = ptr_m2[AW-1:0];
    if (cmd.start_read) begin
      rd_addr = AW'(index);
    end else if (cmd.start_insert) begin
      rd_addr = cnt_m1[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (cmd.shift) begin
      mem[ptr[AW-1:0]] <= rd_data;
    end else if (cmd.place) begin
      mem[ptr[AW-1:0]] <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.place) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_insert) begin
      val <= value;
      ptr <= count;
    end else if (cmd.shift) begin
      ptr <= ptr - CW'(1);
    end
    if (cmd.start_read) begin
      rd_err <= !(XW'(index) < XW'(count));
    end
    if (cmd.take_read) begin
      res_position   <= '0;
      res_read_value <= rd_err ? '0 : rd_data;
      res_error      <= rd_err;
    end else if (cmd.refuse) begin
      res_position   <= '0;
      res_read_value <= '0;
      res_error      <= 1'b1;
    end else if (cmd.place) begin
      res_position   <= ptr;
      res_read_value <= '0;
      res_error      <= 1'b0;
    end
    if (cmd.push) begin
      position    <= FIELD_CNT_W'(res_position);
      read_value  <= res_read_value;
      error       <= res_error;
      entry_count <= FIELD_CNT_W'(count);
      table_empty <= (count == '0);
    end
  end

  assign status.full     = (count == CW'(DEPTH));
  assign status.empty    = (count == '0);
  assign status.ptr_one  = (ptr == CW'(1));
  assign status.shift_ok = (rd_data >= val);

  `SIT_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "count above depth")
  `SIT_ASSERT_NEXT(a_place_grows, cmd.place, count == $past(count) + CW'(1), "place lost count")
  `SIT_ASSERT_NOW(a_place_room, cmd.place, !status.full, "place into full table")

endmodule

### hdl/sit_ctrl.sv
// controller sequencing reads, insert scans and result hand-off
module sit_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             kind,
  output logic             out_valid,
  input  logic             out_ready,
  output sit_pkg::cmd_t    cmd,
  input  sit_pkg::status_t status
);
  import sit_pkg::*;

  `include "sorted_insert_table_defines.svh"

  typedef enum logic [2:0] {
    IDLE,
    RD_WAIT,
    SCAN,
    PLACE,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   ins_take;

  assign in_ready = (state == IDLE);
  assign ins_take = in_valid && in_ready && kind == KIND_INSERT && !status.full;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          if (kind == KIND_READ) begin
            cmd.start_read = 1'b1;
            state_next     = RD_WAIT;
          end else if (status.full) begin
            cmd.refuse = 1'b1;
            state_next = FINISH;
          end else begin
            cmd.start_insert = 1'b1;
            state_next       = status.empty ? PLACE : SCAN;
          end
        end
      end
      RD_WAIT: begin
        cmd.take_read = 1'b1;
        state_next    = FINISH;
      end
      SCAN: begin
        if (status.shift_ok) begin
          cmd.shift = 1'b1;
          if (status.ptr_one) begin
            state_next = PLACE;
          end
        end else begin
          state_next = PLACE;
        end
      end
      PLACE: begin
        cmd.place  = 1'b1;
        state_next = FINISH;
      end
      FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.push   = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SIT_ASSERT_NOW(a_scan_nonempty, state == SCAN, !status.empty, "scan on empty table")
  `SIT_ASSERT_NEXT(a_push_valid, cmd.push, out_valid, "pushed word not shown")
  `SIT_ASSERT_NEXT(a_insert_start, ins_take, state == SCAN || state == PLACE, "insert did not start")

endmodule

### hdl/sorted_insert_table.sv
// sorted insert table: ascending table of signed words with insert and read
// usage:
//   req carries one word per item: kind (insert or read), value, index
//   rsp returns one word per item: position, read_value, entry_count,
//   table_empty and error; a word moves when valid and ready are both high
// sequence of an item, from acceptance until rsp is loaded:
//   read: one registered memory read of the requested index
//   insert into an empty table: the value is placed at position 0
//   insert into a non-empty table: the scan walks down from the top and
//   moves one entry per cycle through the single write port of the table
//   memory while entries are not below the value, then places it there
//   insert into a full table: refused with error set
// one item is worked at a time; req is ready again the cycle after the
// result has been moved into the output register, so no new item is taken
// before the last one's result is there, and the next item is taken
// while the previous word still waits on a stalled rsp
// a stalled rsp holds its word; a finished result waits until the
// output register frees up
// reset (rst, synchronous) empties the table at once and drops rsp valid
module sorted_insert_table #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  sit_in_if.sink    req,
  sit_out_if.source rsp
);
  import sit_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: accepts items, steps the insert scan, owns rsp valid
  sit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .kind      (req.kind),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath: table memory, count, scan pointer and the result word
  sit_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .value       (req.value),
    .index       (req.index),
    .position    (rsp.position),
    .read_value  (rsp.read_value),
    .entry_count (rsp.entry_count),
    .table_empty (rsp.table_empty),
    .error       (rsp.error)
  );

endmodule

### bench/tb.sv
// self-checking testbench for the sorted insert table
module tb;
  import sit_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int RANDOM_WORDS = 480;
  // drain time at the end of the run, for any word still in flight
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // one response word, fields in the order of the rsp channel
  typedef struct packed {
    logic [FIELD_CNT_W-1:0]    position;
    logic signed [VALUE_W-1:0] read_value;
    logic [FIELD_CNT_W-1:0]    entry_count;
    logic                      table_empty;
    logic                      error;
  } rsp_word_t;

  // one request word, optionally with a hand-written expected response
  typedef struct {
    kind_t                     kind;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
    bit                        typed;
    rsp_word_t                 want;
  } req_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sit_in_if  req_if ();
  sit_out_if rsp_if ();

  sorted_insert_table #(
    .DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: a shadow copy of the sorted table
  logic signed [VALUE_W-1:0] stored [TABLE_DEPTH];
  int                        n_stored = 0;

  req_word_t request_words [$];   // words waiting to be driven on req
  rsp_word_t pending_results [$]; // responses owed by the block, oldest first
  req_word_t directed_rows [$];

  int n_sent     = 0;
  int n_checked  = 0;
  int n_placed   = 0;
  int n_refused  = 0;
  int n_fail     = 0;
  int n_random   = 0;
  int send_pause = 0;
  int recv_pause = 0;

  // build one directed row; the trailing fields only matter when typed is set
  function automatic req_word_t row(kind_t k, logic signed [VALUE_W-1:0] v, int i,
                                    int typed, int pos = 0,
                                    logic signed [VALUE_W-1:0] rd = 0,
                                    int cnt = 0, int emp = 0, int err = 0);
    req_word_t w;
    w.kind             = k;
    w.value            = v;
    w.index            = i[INDEX_W-1:0];
    w.typed            = (typed != 0);
    w.want.position    = pos[FIELD_CNT_W-1:0];
    w.want.read_value  = rd;
    w.want.entry_count = cnt[FIELD_CNT_W-1:0];
    w.want.table_empty = (emp != 0);
    w.want.error       = (err != 0);
    return w;
  endfunction

  // apply one accepted word to the shadow table and return the response it owes
  function automatic rsp_word_t place_or_read(req_word_t w);
    rsp_word_t r;
    int        slot;
    r = '0;
    if (w.kind == KIND_INSERT) begin
      if (n_stored >= TABLE_DEPTH) begin
        // full table: refused, table untouched
        r.error = 1'b1;
        n_refused++;
      end else begin
        // first entry not smaller than the new value, so ties go in front
        slot = 0;
        while (slot < n_stored && w.value > stored[slot]) slot++;
        for (int j = n_stored; j > slot; j--) stored[j] = stored[j-1];
        stored[slot] = w.value;
        n_stored++;
        r.position = slot[FIELD_CNT_W-1:0];
        n_placed++;
      end
    end else if (int'(w.index) < n_stored) begin
      r.read_value = stored[w.index];
    end else begin
      // read at or past the count
      r.error = 1'b1;
    end
    r.entry_count = n_stored[FIELD_CNT_W-1:0];
    r.table_empty = (n_stored == 0);
    return r;
  endfunction

  // random word biased toward ties, neighbors of stored values and the count edge
  function automatic req_word_t make_random_word();
    req_word_t w;
    int        pick;
    int        tail;
    w.typed = 1'b0;
    w.want  = '0;
    w.kind  = ($urandom_range(0, 99) < ((n_stored < TABLE_DEPTH) ? 40 : 20)) ?
              KIND_INSERT : KIND_READ;
    pick = $urandom_range(0, 5);
    case (pick)
      2: begin
        w.value = $signed($urandom_range(0, 16)) - 8;
      end
      3: begin
        case ($urandom_range(0, 3))
          0: w.value = VAL_MIN;
          1: w.value = VAL_MAX;
          2: w.value = 0;
          default: w.value = -1;
        endcase
      end
      4: begin
        // exact copy of a stored entry
        w.value = (n_stored > 0) ? stored[$urandom_range(0, n_stored - 1)] : $urandom;
      end
      5: begin
        // one above or below a stored entry
        w.value = (n_stored > 0) ?
                  stored[$urandom_range(0, n_stored - 1)] + ($urandom_range(0, 1) ? 1 : -1) :
                  $urandom;
      end
      default: begin
        w.value = $urandom;
      end
    endcase
    if ($urandom_range(0, 3) == 0 && n_stored > 0) begin
      // land on the last entry or just past it
      tail    = n_stored - int'($urandom_range(0, 1));
      w.index = INDEX_W'((tail > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : tail);
    end else begin
      w.index = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
    end
    return w;
  endfunction

  // idle cycles before the next word; every third block of 40 words runs flat out
  function automatic int draw_pause(int done);
    return (((done / 40) % 3) == 1) ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      n_fail++;
    end
  endfunction

  // request side: one nonblocking update of valid per edge
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      send_pause = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        // word taken: predict now so the shadow table follows acceptance order
        rsp_word_t owed;
        owed = place_or_read(request_words[0]);
        pending_results.push_back(request_words[0].typed ? request_words[0].want : owed);
        void'(request_words.pop_front());
        n_sent++;
        send_pause = draw_pause(n_sent);
      end
      if (send_pause > 0) begin
        req_if.valid <= 1'b0;
        send_pause--;
      end else if (request_words.size() > 0) begin
        req_if.valid <= 1'b1;
        req_if.kind  <= request_words[0].kind;
        req_if.value <= request_words[0].value;
        req_if.index <= request_words[0].index;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response side: stall ready at random, check every word taken
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      recv_pause = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("response word with nothing outstanding");
          n_fail++;
        end else begin
          rsp_word_t want;
          want = pending_results.pop_front();
          compare_field("position", 32'(want.position), 32'(rsp_if.position));
          compare_field("read_value", want.read_value, rsp_if.read_value);
          compare_field("entry_count", 32'(want.entry_count), 32'(rsp_if.entry_count));
          compare_field("table_empty", 32'(want.table_empty), 32'(rsp_if.table_empty));
          compare_field("error", 32'(want.error), 32'(rsp_if.error));
        end
        n_checked++;
        recv_pause = draw_pause(n_checked);
      end
      if (recv_pause > 0) begin
        rsp_if.ready <= 1'b0;
        recv_pause--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.kind  = KIND_INSERT;
    req_if.value = '0;
    req_if.index = '0;
    rsp_if.ready = 1'b0;

    // directed table: kind, value, index, typed, then position, read_value,
    // entry_count, table_empty, error where the answer is obvious
    directed_rows = '{
      // reads on an empty table
      row(KIND_READ,   0,        0,  1, 0, 0,       0, 1, 1),
      row(KIND_READ,   -1,       15, 1, 0, 0,       0, 1, 1),
      // extremes, ties go in front of equal entries
      row(KIND_INSERT, 0,        0,  1, 0, 0,       1, 0, 0),
      row(KIND_INSERT, VAL_MAX,  0,  1, 1, 0,       2, 0, 0),
      row(KIND_INSERT, VAL_MIN,  0,  1, 0, 0,       3, 0, 0),
      row(KIND_INSERT, 0,        0,  1, 1, 0,       4, 0, 0),
      row(KIND_INSERT, -1,       0,  1, 1, 0,       5, 0, 0),
      row(KIND_INSERT, VAL_MAX,  15, 1, 4, 0,       6, 0, 0),
      row(KIND_INSERT, VAL_MIN,  0,  1, 0, 0,       7, 0, 0),
      // reads at both ends, at the count and past it
      row(KIND_READ,   0,        0,  1, 0, VAL_MIN, 7, 0, 0),
      row(KIND_READ,   0,        6,  1, 0, VAL_MAX, 7, 0, 0),
      row(KIND_READ,   VAL_MAX,  7,  1, 0, 0,       7, 0, 1),
      row(KIND_READ,   0,        15, 1, 0, 0,       7, 0, 1),
      row(KIND_READ,   0,        2,  1, 0, -1,      7, 0, 0),
      // index ignored on insert, value ignored on read
      row(KIND_INSERT, 5,        15, 1, 5, 0,       8, 0, 0),
      row(KIND_READ,   32'shdeadbeef, 5, 1, 0, 5,  8, 0, 0),
      // left to the predictor
      row(KIND_READ,   0,        3,  0),
      row(KIND_INSERT, 1,        0,  0),
      row(KIND_READ,   0,        4,  0),
      row(KIND_INSERT, 32'sh4000_0000, 9, 0)
    };
    foreach (directed_rows[i]) request_words.push_back(directed_rows[i]);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // random part generated just ahead of the driver so it sees the current table
    while (n_random < RANDOM_WORDS) begin
      @(negedge clk);
      if (request_words.size() < 2) begin
        request_words.push_back(make_random_word());
        n_random++;
      end
    end

    do @(negedge clk);
    while (request_words.size() != 0 || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d request words (%0d directed), %0d response words checked",
             n_sent, directed_rows.size(), n_checked);
    $display("run: %0d values placed, %0d inserts refused on a full table, %0d mismatches",
             n_placed, n_refused, n_fail);
    if (n_fail == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule
